// ----- rtl/core/cafld_pkg.sv -----
// Shared types and constants for the cubic anisotropy field block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package cafld_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_K1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MOMENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_COEFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_TWO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_THREE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOLUME = 3'd7;

    // Q1.30 unity, the cosine clamp
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic [31:0]        inv_moment;
        logic [31:0]        field_coeff;
        logic [59:0]        axis_one;
        logic [59:0]        axis_two;
        logic [59:0]        axis_three;
        logic [31:0]        inv_volume;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] moment_x;
        logic signed [31:0] moment_y;
        logic signed [31:0] moment_z;
        logic               cell_filled;
        logic               last_cell;
    } job_t;

    // queue handshake between front and back
    typedef struct packed {
        logic avail;
        logic pop;
    } queue_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_COS,
        ST_CSAT,
        ST_SQ,
        ST_AB,
        ST_B,
        ST_SUM,
        ST_T,
        ST_FLD,
        ST_FSAT,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/cafld_front.sv -----
// Front end: configuration registers and a two-entry request queue.
// Depends on cafld_pkg.
`default_nettype none
module cafld_front (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [cafld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [cafld_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  cafld_pkg::job_t                    in_job,
    output cafld_pkg::cfg_t                    cfg,
    output cafld_pkg::job_t                    head_job,
    input  wire                                pop,
    output cafld_pkg::queue_ctl_t              qctl
);
    import cafld_pkg::*;

    cfg_t        cfg_reg;
    job_t        q_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        rd_ptr_reg, wr_ptr_reg;
    logic        push, do_pop;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign do_pop    = pop && (count_reg != 2'd0);
    assign head_job  = q_reg[rd_ptr_reg];
    assign qctl.avail = (count_reg != 2'd0);
    assign qctl.pop   = do_pop;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= '0;
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_K1:          cfg_reg.k1 <= cfg_data[31:0];
                    REG_K2:          cfg_reg.k2 <= cfg_data[31:0];
                    REG_INV_MOMENT:  cfg_reg.inv_moment <= cfg_data[31:0];
                    REG_FIELD_COEFF: cfg_reg.field_coeff <= cfg_data[31:0];
                    REG_AXIS_ONE:    cfg_reg.axis_one <= cfg_data[59:0];
                    REG_AXIS_TWO:    cfg_reg.axis_two <= cfg_data[59:0];
                    REG_AXIS_THREE:  cfg_reg.axis_three <= cfg_data[59:0];
                    REG_INV_VOLUME:  cfg_reg.inv_volume <= cfg_data[31:0];
                    default:         cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/core/cafld_back.sv -----
// Back end: multi-cycle datapath for cosines, field, energy and density.
// Depends on cafld_pkg; fed by cafld_front.
`default_nettype none
module cafld_back #(
    parameter int FIELD_WIDTH = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  cafld_pkg::cfg_t             cfg,
    input  cafld_pkg::job_t             head_job,
    input  cafld_pkg::queue_ctl_t       qctl,
    output logic                        pop,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic signed [FIELD_WIDTH-1:0] field_x,
    output logic signed [FIELD_WIDTH-1:0] field_y,
    output logic signed [FIELD_WIDTH-1:0] field_z,
    output logic signed [31:0]          cell_energy,
    output logic signed [63:0]          energy_density,
    output logic                        sweep_done
);
    import cafld_pkg::*;

    localparam logic [57:0] FPOS = 58'((64'd1 << (FIELD_WIDTH - 1)) - 64'd1);
    localparam logic [57:0] FNEG = 58'(64'd1 << (FIELD_WIDTH - 1));

    back_state_t state_reg, state_next;
    logic        out_load;
    logic        out_valid_reg;

    job_t               job_reg;
    logic signed [53:0] dot_reg [3];
    logic               cn_reg [3];  // cosine sign
    logic [63:0]        cl_reg [3];  // low half partial products
    logic [53:0]        ch_reg [3];  // high half partial products
    logic signed [31:0] d_reg [3];
    logic signed [31:0] s_reg [3];
    logic signed [31:0] p_reg [3];   // d1d2, d1d3, d2d3
    logic signed [33:0] a_reg [3];
    logic signed [31:0] d123_reg;
    logic signed [31:0] ss_reg [3];  // s1s2, s1s3, s2s3
    logic signed [31:0] b_reg [3];
    logic signed [33:0] pk_reg;
    logic signed [31:0] qk_reg;
    logic signed [31:0] sa_reg [3];
    logic signed [31:0] sb_reg [3];
    logic signed [31:0] e_reg;
    logic signed [65:0] t_reg [3];
    logic signed [63:0] sum_reg;
    logic               fn_reg [3];  // field sign
    logic [63:0]        fl_reg [3];
    logic [65:0]        fh_reg [3];
    logic               dn_reg;      // density sign
    logic [63:0]        dl_reg;
    logic [63:0]        dh_reg;
    logic signed [FIELD_WIDTH-1:0] fld_reg [3];
    logic signed [63:0] den_reg;

    logic signed [FIELD_WIDTH-1:0] fx_reg, fy_reg, fz_reg;
    logic signed [31:0] ce_reg;
    logic signed [63:0] ed_reg;
    logic               sd_reg;

    function automatic logic signed [19:0] comp(input logic [59:0] ax, input int i);
        comp = $signed(ax[20*i +: 20]);
    endfunction

    function automatic logic signed [35:0] mulq(input logic signed [33:0] x,
                                                input logic signed [33:0] y);
        logic signed [67:0] pr;
        pr = 68'(x) * 68'(y);
        mulq = 36'(pr >>> 30);
    endfunction

    // combine halves of |dot|*inv, shift, clamp to unity, restore sign
    function automatic logic signed [31:0] cosq(input logic neg,
                                                input logic [63:0] lo,
                                                input logic [53:0] hi);
        logic [85:0] pr;
        logic [49:0] r;
        logic [30:0] rc;
        pr  = 86'(lo) + {hi, 32'b0};
        r   = pr[85:36];
        rc  = (r > 50'(ONE_Q30)) ? ONE_Q30 : r[30:0];
        cosq = neg ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
    endfunction

    function automatic logic signed [FIELD_WIDTH-1:0] fieldq(input logic neg,
                                                             input logic [63:0] lo,
                                                             input logic [65:0] hi);
        logic [97:0] pr;
        logic [57:0] r;
        pr = 98'(lo) + {hi, 32'b0};
        r  = pr[97:40];
        if (neg)
        begin
            r = (r > FNEG) ? FNEG : r;
            fieldq = FIELD_WIDTH'(-$signed({1'b0, r}));
        end
        else
        begin
            r = (r > FPOS) ? FPOS : r;
            fieldq = FIELD_WIDTH'(r);
        end
    endfunction

    function automatic logic signed [63:0] densq(input logic neg,
                                                 input logic [63:0] lo,
                                                 input logic [63:0] hi);
        logic [95:0] pr;
        logic [63:0] r;
        pr = 96'(lo) + {hi, 32'b0};
        r  = pr[95:32];
        if (neg)
        begin
            r = (r > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : r;
            densq = -$signed(r);
        end
        else
        begin
            r = (r > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : r;
            densq = $signed(r);
        end
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (qctl.avail) state_next = ST_DOT;
            ST_DOT:  state_next = ST_COS;
            ST_COS:  state_next = ST_CSAT;
            ST_CSAT: state_next = ST_SQ;
            ST_SQ:   state_next = ST_AB;
            ST_AB:   state_next = ST_B;
            ST_B:    state_next = ST_SUM;
            ST_SUM:  state_next = ST_T;
            ST_T:    state_next = ST_FLD;
            ST_FLD:  state_next = ST_FSAT;
            ST_FSAT: state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop = qctl.avail;
            ST_OUT:  out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_T && job_reg.cell_filled)
            begin
                logic signed [64:0] acc;
                acc = 65'(sum_reg) + 65'(e_reg);
                if (acc > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                begin
                    sum_reg <= 64'sh7FFF_FFFF_FFFF_FFFF;
                end
                else if (acc < -65'sh0_8000_0000_0000_0000)
                begin
                    sum_reg <= 64'sh8000_0000_0000_0000;
                end
                else
                begin
                    sum_reg <= acc[63:0];
                end
            end
            else if (state_reg == ST_FLD && job_reg.last_cell)
            begin
                sum_reg <= '0;
            end
        end
    end

    // datapath, one step per state; wide products are split in two halves
    always_ff @(posedge clk)
    begin
        logic [59:0]        ax [3];
        logic signed [67:0] acc67;
        logic signed [55:0] fa, fb;
        logic [53:0]        cmag;
        logic [65:0]        fmag;
        logic [63:0]        dmag;
        ax[0] = cfg.axis_one;
        ax[1] = cfg.axis_two;
        ax[2] = cfg.axis_three;
        acc67 = '0;
        fa = '0;
        fb = '0;
        cmag = '0;
        fmag = '0;
        dmag = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (qctl.avail)
                begin
                    job_reg <= head_job;
                end
            end
            ST_DOT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dot_reg[k] <= 54'(job_reg.moment_x) * 54'(comp(ax[k], 0))
                                + 54'(job_reg.moment_y) * 54'(comp(ax[k], 1))
                                + 54'(job_reg.moment_z) * 54'(comp(ax[k], 2));
                end
            end
            ST_COS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cmag = dot_reg[k][53] ? 54'(-dot_reg[k]) : 54'(dot_reg[k]);
                    cn_reg[k] <= dot_reg[k][53];
                    cl_reg[k] <= 64'(cmag[31:0]) * 64'(cfg.inv_moment);
                    ch_reg[k] <= 54'(cmag[53:32]) * 54'(cfg.inv_moment);
                end
            end
            ST_CSAT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_reg[k] <= cosq(cn_reg[k], cl_reg[k], ch_reg[k]);
                end
            end
            ST_SQ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s_reg[k] <= 32'(mulq(34'(d_reg[k]), 34'(d_reg[k])));
                end
                p_reg[0] <= 32'(mulq(34'(d_reg[0]), 34'(d_reg[1])));
                p_reg[1] <= 32'(mulq(34'(d_reg[0]), 34'(d_reg[2])));
                p_reg[2] <= 32'(mulq(34'(d_reg[1]), 34'(d_reg[2])));
            end
            ST_AB:
            begin
                a_reg[0] <= 34'(mulq(34'(d_reg[0]), 34'(s_reg[1]) + 34'(s_reg[2])));
                a_reg[1] <= 34'(mulq(34'(d_reg[1]), 34'(s_reg[0]) + 34'(s_reg[2])));
                a_reg[2] <= 34'(mulq(34'(d_reg[2]), 34'(s_reg[0]) + 34'(s_reg[1])));
                d123_reg <= 32'(mulq(34'(p_reg[0]), 34'(d_reg[2])));
                ss_reg[0] <= 32'(mulq(34'(s_reg[0]), 34'(s_reg[1])));
                ss_reg[1] <= 32'(mulq(34'(s_reg[0]), 34'(s_reg[2])));
                ss_reg[2] <= 32'(mulq(34'(s_reg[1]), 34'(s_reg[2])));
            end
            ST_B:
            begin
                b_reg[0] <= 32'(mulq(34'(d123_reg), 34'(p_reg[2])));
                b_reg[1] <= 32'(mulq(34'(d123_reg), 34'(p_reg[1])));
                b_reg[2] <= 32'(mulq(34'(d123_reg), 34'(p_reg[0])));
                pk_reg <= 34'((34'(ss_reg[0]) + 34'(ss_reg[1]) + 34'(ss_reg[2])) >>> 6);
                qk_reg <= 32'((64'(d123_reg) * 64'(d123_reg)) >>> 36);
            end
            ST_SUM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fa = 56'(comp(ax[0], i)) * 56'(a_reg[0])
                       + 56'(comp(ax[1], i)) * 56'(a_reg[1])
                       + 56'(comp(ax[2], i)) * 56'(a_reg[2]);
                    fb = 56'(comp(ax[0], i)) * 56'(b_reg[0])
                       + 56'(comp(ax[1], i)) * 56'(b_reg[1])
                       + 56'(comp(ax[2], i)) * 56'(b_reg[2]);
                    sa_reg[i] <= 32'(fa >>> 24);
                    sb_reg[i] <= 32'(fb >>> 24);
                end
                acc67 = (68'(cfg.k1) * 68'(pk_reg) + 68'(cfg.k2) * 68'(qk_reg)) >>> 24;
                if (acc67 > 68'sd2147483647)
                begin
                    e_reg <= 32'sh7FFF_FFFF;
                end
                else if (acc67 < -68'sd2147483648)
                begin
                    e_reg <= 32'sh8000_0000;
                end
                else
                begin
                    e_reg <= acc67[31:0];
                end
            end
            ST_T:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t_reg[i] <= 66'(cfg.k1) * 66'(sa_reg[i]) + 66'(cfg.k2) * 66'(sb_reg[i]);
                end
            end
            ST_FLD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fmag = t_reg[i][65] ? 66'(-t_reg[i]) : 66'(t_reg[i]);
                    fn_reg[i] <= (t_reg[i] > 66'sd0);   // field is -t times the coefficient
                    fl_reg[i] <= 64'(fmag[31:0]) * 64'(cfg.field_coeff);
                    fh_reg[i] <= 66'(fmag[65:32]) * 66'(cfg.field_coeff);
                end
                dmag = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
                dn_reg <= sum_reg[63];
                dl_reg <= 64'(dmag[31:0]) * 64'(cfg.inv_volume);
                dh_reg <= 64'(dmag[63:32]) * 64'(cfg.inv_volume);
            end
            ST_FSAT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fld_reg[i] <= fieldq(fn_reg[i], fl_reg[i], fh_reg[i]);
                end
                den_reg <= densq(dn_reg, dl_reg, dh_reg);
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    fx_reg <= job_reg.cell_filled ? fld_reg[0] : '0;
                    fy_reg <= job_reg.cell_filled ? fld_reg[1] : '0;
                    fz_reg <= job_reg.cell_filled ? fld_reg[2] : '0;
                    ce_reg <= job_reg.cell_filled ? e_reg : '0;
                    ed_reg <= job_reg.last_cell ? den_reg : '0;
                    sd_reg <= job_reg.last_cell;
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign field_x        = fx_reg;
    assign field_y        = fy_reg;
    assign field_z        = fz_reg;
    assign cell_energy    = ce_reg;
    assign energy_density = ed_reg;
    assign sweep_done     = sd_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("queue pop outside idle");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLD && job_reg.last_cell) |=> sum_reg == 64'sd0)
        else $error("energy sum not cleared after last cell");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQ |-> (d_reg[0] <= 32'sh4000_0000 && d_reg[0] >= -32'sh4000_0000))
        else $error("cosine outside unit range");

    a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result lost on load");

endmodule
`default_nettype wire

// ----- rtl/core/cubic_anisotropy_field.sv -----
// Top level of the cubic anisotropy field block: front queue plus back datapath.
// Depends on cafld_pkg, cafld_front and cafld_back.
//
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------
// cfg      | cfg_valid/cfg_ready | cfg_index (register 0..7), cfg_data
// s_axis   | s_tvalid/s_tready   | s_tdata moments, s_tuser filled, s_tlast
// m_axis   | m_tvalid/m_tready   | m_tdata field/energy/density, m_tlast
//
// Each request passes through the back-end sequencer states DOT, COS, CSAT, SQ,
// AB, B, SUM, T, FLD, FSAT and OUT (one state per multiply step, wide products
// split over two states) after the idle state pulls it from the queue; OUT holds
// while m_tready is low and a result waits. The two-entry queue keeps accepting,
// up to full, while the back end works and while a result waits in the output register.
// Reset clears configuration, queue pointers, sequencer and energy sum.
`default_nettype none
module cubic_anisotropy_field #(
    parameter int FIELD_WIDTH = 32
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [cafld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [cafld_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // moment_x [31:0], moment_y [63:32], moment_z [95:64]
    input  wire [95:0]                         s_tdata,
    // cell_filled [0]
    input  wire                                s_tuser,
    input  wire                                s_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // field_x, field_y, field_z (FIELD_WIDTH each), cell_energy 32,
    // energy_density 64, zero pad to bytes
    output logic [((3*FIELD_WIDTH+96+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast
);
    import cafld_pkg::*;

    localparam int TDW = ((3*FIELD_WIDTH+96+7)/8)*8;

    cfg_t       cfg;
    job_t       in_job, head_job;
    queue_ctl_t qctl;
    logic       pop;
    logic signed [FIELD_WIDTH-1:0] fx, fy, fz;
    logic signed [31:0] ce;
    logic signed [63:0] ed;

    assign in_job.moment_x    = s_tdata[31:0];
    assign in_job.moment_y    = s_tdata[63:32];
    assign in_job.moment_z    = s_tdata[95:64];
    assign in_job.cell_filled = s_tuser;
    assign in_job.last_cell   = s_tlast;

    cafld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_job   (in_job),
        .cfg      (cfg),
        .head_job (head_job),
        .pop      (pop),
        .qctl     (qctl)
    );

    cafld_back #(.FIELD_WIDTH(FIELD_WIDTH)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head_job      (head_job),
        .qctl          (qctl),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .field_x       (fx),
        .field_y       (fy),
        .field_z       (fz),
        .cell_energy   (ce),
        .energy_density(ed),
        .sweep_done    (m_tlast)
    );

    assign m_tdata = TDW'({ed, ce, fz, fy, fx});

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for cubic_anisotropy_field: random cells against an in-bench predictor.
// Depends on cafld_pkg and the RTL under rtl/core.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cafld_pkg::*;

    localparam int FW = 32;
    localparam int MW = ((3*FW+96+7)/8)*8;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int CELLS_PER_PHASE = 230;
    localparam int N_PHASES = 6;

    // wide signed scratch type, roomy enough that no product overflows
    typedef logic signed [127:0] wide_t;
    localparam wide_t Q30_ONE = 128'sh4000_0000;
    localparam wide_t I64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam wide_t I64_NEG = 128'sh8000_0000_0000_0000;
    localparam wide_t I32_MAX = 128'sh7FFF_FFFF;
    localparam wide_t I32_NEG = 128'sh8000_0000;

    typedef struct {
        logic [FW-1:0] fld_x;
        logic [FW-1:0] fld_y;
        logic [FW-1:0] fld_z;
        logic [31:0]   energy;
        logic [63:0]   density;
        logic          done;
    } aniso_res_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [95:0]     s_tdata = '0;   // moment_x, moment_y, moment_z
    logic            s_tuser = 1'b0; // cell_filled
    logic            s_tlast = 1'b0; // last_cell
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [MW-1:0]   m_tdata;        // field_x/y/z, cell_energy, energy_density
    logic            m_tlast;        // sweep_done

    cubic_anisotropy_field #(.FIELD_WIDTH(FW)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the register file and the running energy sum
    cfg_t  shadow_cfg = '0;
    wide_t energy_acc = '0;

    job_t       cell_queue[$];
    aniso_res_t expected_results[$];
    int         n_errors = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function automatic wide_t sx20(logic [19:0] v);
        wide_t r;
        r = $signed(v);
        return r;
    endfunction

    // |a|*b >> s, truncated toward zero, clamped to +pcap / -ncap
    function automatic wide_t mul_shr_trunc(wide_t a, logic [31:0] b, int s,
                                            wide_t pcap, wide_t ncap);
        wide_t bb, mag, r;
        bb = {96'b0, b};
        mag = (a < 0) ? -a : a;
        r = (mag * bb) >> s;
        if (a < 0)
        begin
            if (r > ncap) r = ncap;
            return -r;
        end
        if (r > pcap) r = pcap;
        return r;
    endfunction

    function automatic wide_t qmul(wide_t x, wide_t y);
        wide_t p;
        p = x * y;
        return p >>> 30;
    endfunction

    function automatic wide_t dir_cosine(wide_t m[3], logic [59:0] ax);
        wide_t dot;
        dot = m[0]*sx20(ax[19:0]) + m[1]*sx20(ax[39:20]) + m[2]*sx20(ax[59:40]);
        return mul_shr_trunc(dot, shadow_cfg.inv_moment, 36, Q30_ONE, Q30_ONE);
    endfunction

    function automatic aniso_res_t predict_cell(job_t c);
        aniso_res_t r;
        wide_t m[3], d1, d2, d3, s1, s2, s3, d123, a[3], b[3];
        wide_t k1, k2, e0, e1, e2, sa, sb, t, f, pp, qq, en;
        logic [59:0] ax[3];
        r = '{default: '0};
        if (c.cell_filled)
        begin
            k1 = shadow_cfg.k1;
            k2 = shadow_cfg.k2;
            ax[0] = shadow_cfg.axis_one;
            ax[1] = shadow_cfg.axis_two;
            ax[2] = shadow_cfg.axis_three;
            m[0] = c.moment_x; m[1] = c.moment_y; m[2] = c.moment_z;
            d1 = dir_cosine(m, ax[0]);
            d2 = dir_cosine(m, ax[1]);
            d3 = dir_cosine(m, ax[2]);
            s1 = qmul(d1, d1); s2 = qmul(d2, d2); s3 = qmul(d3, d3);
            a[0] = qmul(d1, s2 + s3);
            a[1] = qmul(d2, s1 + s3);
            a[2] = qmul(d3, s1 + s2);
            d123 = qmul(qmul(d1, d2), d3);
            b[0] = qmul(d123, qmul(d2, d3));
            b[1] = qmul(d123, qmul(d1, d3));
            b[2] = qmul(d123, qmul(d1, d2));
            for (int i = 0; i < 3; i++)
            begin
                e0 = sx20(ax[0][20*i +: 20]);
                e1 = sx20(ax[1][20*i +: 20]);
                e2 = sx20(ax[2][20*i +: 20]);
                sa = (e0*a[0] + e1*a[1] + e2*a[2]) >>> 24;
                sb = (e0*b[0] + e1*b[1] + e2*b[2]) >>> 24;
                t = k1*sa + k2*sb;
                // field is minus the energy gradient
                f = mul_shr_trunc(-t, shadow_cfg.field_coeff, 40,
                                  (128'sd1 <<< (FW-1)) - 1, 128'sd1 <<< (FW-1));
                if (i == 0) r.fld_x = f[FW-1:0];
                else if (i == 1) r.fld_y = f[FW-1:0];
                else r.fld_z = f[FW-1:0];
            end
            pp = (qmul(s1, s2) + qmul(s1, s3) + qmul(s2, s3)) >>> 6;
            qq = (d123 * d123) >>> 36;
            en = (k1*pp + k2*qq) >>> 24;
            if (en > I32_MAX) en = I32_MAX;
            if (en < -I32_NEG) en = -I32_NEG;
            r.energy = en[31:0];
            energy_acc = energy_acc + en;
            if (energy_acc > I64_MAX) energy_acc = I64_MAX;
            if (energy_acc < -I64_NEG) energy_acc = -I64_NEG;
        end
        if (c.last_cell)
        begin
            en = mul_shr_trunc(energy_acc, shadow_cfg.inv_volume, 32, I64_MAX, I64_NEG);
            r.density = en[63:0];
            r.done = 1'b1;
            energy_acc = '0;
        end
        return r;
    endfunction

    // input side: predict on each accepted request, then offer the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_cell('{$signed(s_tdata[31:0]),
                    $signed(s_tdata[63:32]), $signed(s_tdata[95:64]), s_tuser, s_tlast}));
            if (!s_tvalid || s_tready)
            begin
                if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    job_t c;
                    c = cell_queue.pop_front();
                    s_tdata <= {c.moment_z, c.moment_y, c.moment_x};
                    s_tuser <= c.cell_filled;
                    s_tlast <= c.last_cell;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side: random back-pressure and field-by-field compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h last %b", $time, m_tdata, m_tlast);
                    n_errors++;
                end
                else
                begin
                    aniso_res_t e;
                    aniso_res_t got;
                    e = expected_results.pop_front();
                    got.fld_x = m_tdata[FW-1:0];
                    got.fld_y = m_tdata[2*FW-1:FW];
                    got.fld_z = m_tdata[3*FW-1:2*FW];
                    got.energy = m_tdata[3*FW+31:3*FW];
                    got.density = m_tdata[3*FW+95:3*FW+32];
                    got.done = m_tlast;
                    if (got.fld_x !== e.fld_x)
                    begin
                        $display("%0t: field_x expected %h actual %h", $time, e.fld_x, got.fld_x);
                        n_errors++;
                    end
                    if (got.fld_y !== e.fld_y)
                    begin
                        $display("%0t: field_y expected %h actual %h", $time, e.fld_y, got.fld_y);
                        n_errors++;
                    end
                    if (got.fld_z !== e.fld_z)
                    begin
                        $display("%0t: field_z expected %h actual %h", $time, e.fld_z, got.fld_z);
                        n_errors++;
                    end
                    if (got.energy !== e.energy)
                    begin
                        $display("%0t: cell_energy expected %h actual %h",
                                 $time, e.energy, got.energy);
                        n_errors++;
                    end
                    if (got.density !== e.density)
                    begin
                        $display("%0t: energy_density expected %h actual %h",
                                 $time, e.density, got.density);
                        n_errors++;
                    end
                    if (got.done !== e.done)
                    begin
                        $display("%0t: sweep_done expected %b actual %b", $time, e.done, got.done);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_K1:          shadow_cfg.k1 = val[31:0];
            REG_K2:          shadow_cfg.k2 = val[31:0];
            REG_INV_MOMENT:  shadow_cfg.inv_moment = val[31:0];
            REG_FIELD_COEFF: shadow_cfg.field_coeff = val[31:0];
            REG_AXIS_ONE:    shadow_cfg.axis_one = val[59:0];
            REG_AXIS_TWO:    shadow_cfg.axis_two = val[59:0];
            REG_AXIS_THREE:  shadow_cfg.axis_three = val[59:0];
            default:         shadow_cfg.inv_volume = val[31:0];
        endcase
    endtask

    // wait for the pipe to drain, then a settling margin for the sequencer
    task automatic drain();
        wait (cell_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand32();
        return $urandom();
    endfunction

    // moments of random magnitude so cosines land both inside and at the clamp
    function automatic logic [31:0] rand_moment();
        logic signed [31:0] v;
        v = $urandom();
        return v >>> $urandom_range(31);
    endfunction

    function automatic logic [63:0] rand_axis();
        case ($urandom_range(3))
            0:       return {$urandom(), $urandom()};
            1:       return {4'hF, 20'($urandom_range(0, 1 << 19)), 20'($urandom()),
                             20'($urandom_range(0, 1 << 19))};
            default: return {$urandom(), $urandom()} >> $urandom_range(4, 30);
        endcase
    endfunction

    function automatic job_t rand_cell();
        job_t c;
        c.moment_x = rand_moment();
        c.moment_y = rand_moment();
        c.moment_z = rand_moment();
        c.cell_filled = ($urandom_range(9) != 0);
        c.last_cell = ($urandom_range(19) == 0);
        return c;
    endfunction

    initial
    begin
        job_t c;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            // idle mix: none, sender gaps, receiver stalls, both lightly
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (ph == 0)
            begin
                // easy axes along x, y and z, moderate constants
                write_reg(REG_K1, 64'h0010_0000);
                write_reg(REG_K2, 64'hFFF0_0000);
                write_reg(REG_INV_MOMENT, 64'h0004_0000);
                write_reg(REG_FIELD_COEFF, 64'h0001_0000);
                write_reg(REG_AXIS_ONE, 64'h0000_0000_0004_0000);
                write_reg(REG_AXIS_TWO, 64'h0000_0040_0000_0000 >> 2);
                write_reg(REG_AXIS_THREE, 64'h0004_0000_0000_0000 >> 4);
                write_reg(REG_INV_VOLUME, 64'hFFFF_FFFF);
            end
            else if (ph == 1)
            begin
                // upper extremes, junk in the unused upper bits
                write_reg(REG_K1, 64'hFFFF_FFFF_7FFF_FFFF);
                write_reg(REG_K2, 64'h7FFF_FFFF);
                write_reg(REG_INV_MOMENT, 64'hFFFF_FFFF);
                write_reg(REG_FIELD_COEFF, 64'hFFFF_FFFF);
                write_reg(REG_AXIS_ONE, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(REG_AXIS_TWO, 64'h07FF_FFFF_FFFF_FFFF);
                write_reg(REG_AXIS_THREE, 64'h8008_0000_8000_0000);
                write_reg(REG_INV_VOLUME, 64'hFFFF_FFFF);
            end
            else if (ph == 2)
            begin
                // lower extremes and zero reciprocals
                write_reg(REG_K1, 64'h8000_0000);
                write_reg(REG_K2, 64'h8000_0000);
                write_reg(REG_INV_MOMENT, 64'h0);
                write_reg(REG_FIELD_COEFF, 64'h0);
                write_reg(REG_AXIS_ONE, 64'h0800_0080_0008_0000);
                write_reg(REG_AXIS_TWO, 64'h0);
                write_reg(REG_AXIS_THREE, 64'h0800_0080_0008_0000);
                write_reg(REG_INV_VOLUME, 64'h0);
            end
            else
            begin
                write_reg(REG_K1, rand32());
                write_reg(REG_K2, rand32());
                write_reg(REG_INV_MOMENT, rand32() >> $urandom_range(20));
                write_reg(REG_FIELD_COEFF, rand32());
                write_reg(REG_AXIS_ONE, rand_axis());
                write_reg(REG_AXIS_TWO, rand_axis());
                write_reg(REG_AXIS_THREE, rand_axis());
                write_reg(REG_INV_VOLUME, rand32());
            end

            if (ph == 0)
            begin
                // directed: empty cells, extremes, sweep ends with and without energy
                cell_queue.push_back('{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0});
                cell_queue.push_back('{32'h7FFF_FFFF, 32'sd0, 32'sd0, 1'b1, 1'b0});
                cell_queue.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0});
                cell_queue.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0});
                cell_queue.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0});
                cell_queue.push_back('{32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 1'b1, 1'b1});
                cell_queue.push_back('{32'h1000_0000, 32'hF000_0000, 32'h0800_0000, 1'b0, 1'b1});
                cell_queue.push_back('{32'h0800_0000, 32'h0C00_0000, 32'hF400_0000, 1'b1, 1'b0});
                cell_queue.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1});
                cell_queue.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1});
                cell_queue.push_back('{32'h2000_0000, 32'h2000_0000, 32'sd0, 1'b1, 1'b1});
            end
            for (int n = 0; n < CELLS_PER_PHASE; n++)
            begin
                c = rand_cell();
                cell_queue.push_back(c);
            end
            // close the sweep so the density shows in every setting
            c = rand_cell();
            c.last_cell = 1'b1;
            cell_queue.push_back(c);
            drain();
        end

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/cafld_pkg.sv
rtl/core/cafld_front.sv
rtl/core/cafld_back.sv
rtl/core/cubic_anisotropy_field.sv
tb/testbench.sv
